[hw/rtl/lnge_pkg.sv]
package lnge_pkg;

    localparam int FACTORS = 8;
    localparam int FIDX_W = (FACTORS > 1) ? $clog2(FACTORS) : 1;

    localparam logic [2:0] REG_USE_EXACT = 3'd0;
    localparam logic [2:0] REG_C0 = 3'd1;
    localparam logic [2:0] REG_C1 = 3'd2;
    localparam logic [2:0] REG_C3 = 3'd3;
    localparam logic [2:0] REG_C5 = 3'd4;
    localparam logic [2:0] REG_C7 = 3'd5;
    localparam logic [2:0] REG_STEP = 3'd6;
    localparam logic [2:0] REG_ETA = 3'd7;

    localparam logic OP_ROW = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic operation;
        logic last_sample;
        logic signed [15:0] feature_7;
        logic signed [15:0] feature_6;
        logic signed [15:0] feature_5;
        logic signed [15:0] feature_4;
        logic signed [15:0] feature_3;
        logic signed [15:0] feature_2;
        logic signed [15:0] feature_1;
        logic signed [15:0] feature_0;
    } in_item_t;

    typedef struct packed {
        logic [2:0] factor_index;
        logic signed [31:0] weight_w;
        logic signed [31:0] weight_v;
        logic last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [3:0] index;
        logic [31:0] data;
    } cfg_item_t;

    // Configuration handed to the datapath.
    typedef struct packed {
        logic use_exact;
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c3;
        logic signed [31:0] c5;
        logic signed [31:0] c7;
        logic signed [31:0] step;
        logic signed [31:0] eta;
    } cfg_regs_t;

    // Sigmoid table, s(-a) at a = 0, 0.5, ..., 8 in unsigned Q0.16.
    function automatic logic [15:0] sig_tab(input logic [4:0] i);
        logic [15:0] r;
        case (i)
            5'd0: r = 16'd32768;
            5'd1: r = 16'd24743;
            5'd2: r = 16'd17625;
            5'd3: r = 16'd11955;
            5'd4: r = 16'd7812;
            5'd5: r = 16'd4971;
            5'd6: r = 16'd3108;
            5'd7: r = 16'd1921;
            5'd8: r = 16'd1179;
            5'd9: r = 16'd720;
            5'd10: r = 16'd439;
            5'd11: r = 16'd267;
            5'd12: r = 16'd162;
            5'd13: r = 16'd98;
            5'd14: r = 16'd60;
            5'd15: r = 16'd36;
            default: r = 16'd22;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
        logic signed [31:0] r;
        if (x > 80'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -80'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

[hw/rtl/lnge_lane.sv]
// One lane: product of a look-ahead weight and a feature, and the gradient
// accumulation and weight update for its factor.
module lnge_lane
    import lnge_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic clear,
    input  logic grad_en,
    input  logic upd_en,
    input  logic upd_mix,
    input  logic signed [15:0] feature,
    input  logic signed [31:0] slope,
    input  logic signed [31:0] step,
    input  logic signed [31:0] eta,
    output logic signed [47:0] prod,
    output logic signed [31:0] w,
    output logic signed [31:0] v
);
    logic signed [31:0] w_reg, v_reg;
    logic signed [31:0] tmp_reg;
    logic signed [47:0] g_reg;
    logic signed [47:0] g_next;
    logic signed [49:0] g_sum;
    logic signed [47:0] tx;
    logic signed [31:0] gh;
    logic signed [16:0] gl;
    logic signed [63:0] ph;
    logic signed [49:0] pl;
    logic signed [65:0] pr;
    logic signed [65:0] pc;
    logic signed [31:0] tmp;
    logic signed [32:0] dwt;
    logic signed [64:0] em;
    logic signed [31:0] nv;

    // Inner product term with the look-ahead weight.
    assign prod = v_reg * feature;

    // Gradient term, floor shift and 48-bit saturation.
    always_comb
    begin
        tx = (slope * feature) >>> 12;
        g_sum = 50'(g_reg) + 50'(tx);
        if (g_sum > 50'sh007fffffffffff)
            g_next = 48'sh7fffffffffff;
        else if (g_sum < -50'sh00800000000000)
            g_next = 48'sh800000000000;
        else
            g_next = g_sum[47:0];
    end

    // First update cycle: gradient step from the look-ahead weight.
    always_comb
    begin
        gh = g_reg[47:16];
        gl = {1'b0, g_reg[15:0]};
        ph = step * gh;
        pl = (step * gl) >>> 16;
        pr = 66'(ph) + 66'(pl);
        if (pr > 66'sd1099511627776)
            pc = 66'sd1099511627776;
        else if (pr < -66'sd1099511627776)
            pc = -66'sd1099511627776;
        else
            pc = pr;
        tmp = sat32(80'(v_reg) - 80'(pc));
    end

    // Second update cycle: momentum mix of the stepped weight and the old one.
    always_comb
    begin
        dwt = 33'(w_reg) - 33'(tmp_reg);
        em = (eta * dwt) >>> 16;
        nv = sat32(80'(tmp_reg) + 80'(em));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
            v_reg <= '0;
            g_reg <= '0;
            tmp_reg <= '0;
        end
        else if (clear)
        begin
            w_reg <= '0;
            v_reg <= '0;
            g_reg <= '0;
            tmp_reg <= '0;
        end
        else if (upd_en)
            tmp_reg <= tmp;
        else if (upd_mix)
        begin
            w_reg <= tmp_reg;
            v_reg <= nv;
            g_reg <= '0;
        end
        else if (grad_en)
            g_reg <= g_next;
    end

    assign w = w_reg;
    assign v = v_reg;
endmodule

[hw/rtl/lnge_slope.sv]
// Merging stage: sums lane products into ip, then maps ip to the loss slope
// through the table or the polynomial, one multiply per cycle.
module lnge_slope
    import lnge_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic signed [47:0] prods [FACTORS],
    input  cfg_regs_t cfg,
    output logic done,
    output logic signed [31:0] slope
);
    typedef enum logic [3:0] {S_IDLE, S_SUM, S_P2, S_P3, S_P5, S_P7,
        S_T1, S_T3, S_T5, S_T7, S_TAB} st_t;

    st_t st_reg;
    logic signed [31:0] ip_reg, p2_reg, p3_reg, p5_reg, p7_reg;
    logic signed [79:0] sum_reg;
    logic signed [31:0] slope_reg;
    logic done_reg;
    logic signed [55:0] acc;
    logic signed [31:0] ma, mb;
    logic signed [63:0] mp;
    logic signed [31:0] mq;
    logic signed [31:0] absv;
    logic [4:0] idx;
    logic signed [16:0] lo, hi;
    logic signed [33:0] intp;
    logic signed [31:0] s;

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < FACTORS; i++)
            acc = acc + 56'(prods[i]);
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        ma = ip_reg;
        mb = ip_reg;
        unique case (st_reg)
            S_P2: begin ma = ip_reg; mb = ip_reg; end
            S_P3: begin ma = p2_reg; mb = ip_reg; end
            S_P5: begin ma = p3_reg; mb = p2_reg; end
            S_P7: begin ma = p5_reg; mb = p2_reg; end
            S_T1: begin ma = cfg.c1; mb = ip_reg; end
            S_T3: begin ma = cfg.c3; mb = p3_reg; end
            S_T5: begin ma = cfg.c5; mb = p5_reg; end
            S_T7: begin ma = cfg.c7; mb = p7_reg; end
            default: begin ma = ip_reg; mb = ip_reg; end
        endcase
        mp = ma * mb;
        mq = sat32(80'(mp >>> 16));
    end

    // Table interpolation.
    always_comb
    begin
        absv = ip_reg[31] ? -ip_reg : ip_reg;
        idx = (absv[31:15] >= 17'd16) ? 5'd16 : absv[19:15];
        lo = {1'b0, sig_tab(idx)};
        hi = (idx == 5'd16) ? lo : {1'b0, sig_tab(5'(idx + 5'd1))};
        intp = ((hi - lo) * $signed({1'b0, absv[14:0]})) >>> 15;
        if (ip_reg[31] && ip_reg == 32'sh80000000)
            s = 32'(lo);
        else
            s = 32'(lo) + 32'(intp);
        if (idx == 5'd16)
            s = 32'(lo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (start) st_reg <= S_SUM;
                S_SUM:
                begin
                    ip_reg <= sat32(80'(acc >>> 12));
                    st_reg <= cfg.use_exact ? S_TAB : S_P2;
                end
                S_TAB:
                begin
                    slope_reg <= ip_reg[31] ? s - 32'sd65536 : -s;
                    done_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                S_P2: begin p2_reg <= mq; st_reg <= S_P3; end
                S_P3: begin p3_reg <= mq; st_reg <= S_P5; end
                S_P5: begin p5_reg <= mq; st_reg <= S_P7; end
                S_P7: begin p7_reg <= mq; st_reg <= S_T1; end
                S_T1:
                begin
                    sum_reg <= 80'(cfg.c0) + 80'(mp >>> 16);
                    st_reg <= S_T3;
                end
                S_T3: begin sum_reg <= sum_reg + 80'(mp >>> 16); st_reg <= S_T5; end
                S_T5: begin sum_reg <= sum_reg + 80'(mp >>> 16); st_reg <= S_T7; end
                S_T7:
                begin
                    slope_reg <= sat32(sum_reg + 80'(mp >>> 16));
                    done_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign slope = slope_reg;
endmodule

[hw/rtl/logreg_nesterov_gradient_epoch_top.sv]
// One epoch of Nesterov gradient descent for logistic regression over FACTORS
// lanes. With the polynomial sigmoid a row is paced by the shared multiplier,
// which steps through the powers and terms one after another. After the last
// row all lanes update at once (gradient step, then momentum mix), and the
// FACTORS results drain from the lane weight registers, one per cycle as the
// consumer takes them; no new row enters until drained.
module logreg_nesterov_gradient_epoch_top
    import lnge_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_item_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_item_t out_data,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  cfg_item_t cfg_data
);
    typedef enum logic [2:0] {T_IDLE, T_SLOPE, T_GRAD, T_UPD, T_MIX, T_OUT} tst_t;

    tst_t st_reg;
    cfg_regs_t cfg_reg;
    in_item_t item_reg;
    logic [FIDX_W:0] oi_reg;
    logic start;
    logic done;
    logic signed [31:0] slope;
    logic signed [47:0] prods [FACTORS];
    logic signed [31:0] ws [FACTORS];
    logic signed [31:0] vs [FACTORS];
    logic signed [15:0] feats [8];
    logic clear, grad_en, upd_en, upd_mix;

    assign feats[0] = item_reg.feature_0;
    assign feats[1] = item_reg.feature_1;
    assign feats[2] = item_reg.feature_2;
    assign feats[3] = item_reg.feature_3;
    assign feats[4] = item_reg.feature_4;
    assign feats[5] = item_reg.feature_5;
    assign feats[6] = item_reg.feature_6;
    assign feats[7] = item_reg.feature_7;

    assign in_ready = (st_reg == T_IDLE);
    assign cfg_ready = 1'b1;
    assign clear = in_valid && in_ready && (in_data.operation == OP_CLEAR);
    assign start = (st_reg == T_SLOPE);
    assign grad_en = (st_reg == T_GRAD) && done;
    assign upd_en = (st_reg == T_UPD);
    assign upd_mix = (st_reg == T_MIX);

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{use_exact: 1'b1, default: '0};
        else if (cfg_valid && cfg_ready && !cfg_data.index[3])
        begin
            unique case (cfg_data.index[2:0])
                REG_USE_EXACT: cfg_reg.use_exact <= cfg_data.data[0];
                REG_C0: cfg_reg.c0 <= cfg_data.data;
                REG_C1: cfg_reg.c1 <= cfg_data.data;
                REG_C3: cfg_reg.c3 <= cfg_data.data;
                REG_C5: cfg_reg.c5 <= cfg_data.data;
                REG_C7: cfg_reg.c7 <= cfg_data.data;
                REG_STEP: cfg_reg.step <= cfg_data.data;
                REG_ETA: cfg_reg.eta <= cfg_data.data;
                default: ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < FACTORS; g++)
        begin : g_lane
            lnge_lane u_lane (
                .clk(clk), .rst_n(rst_n), .clear(clear), .grad_en(grad_en),
                .upd_en(upd_en), .upd_mix(upd_mix), .feature(feats[g]),
                .slope(slope), .step(cfg_reg.step), .eta(cfg_reg.eta),
                .prod(prods[g]), .w(ws[g]), .v(vs[g])
            );
        end
    endgenerate

    lnge_slope u_slope (
        .clk(clk), .rst_n(rst_n), .start(start), .prods(prods), .cfg(cfg_reg),
        .done(done), .slope(slope)
    );

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= T_IDLE;
            oi_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                T_IDLE:
                    if (in_valid && in_data.operation == OP_ROW)
                    begin
                        item_reg <= in_data;
                        st_reg <= T_SLOPE;
                    end
                T_SLOPE: st_reg <= T_GRAD;
                T_GRAD:
                    if (done)
                        st_reg <= item_reg.last_sample ? T_UPD : T_IDLE;
                T_UPD: st_reg <= T_MIX;
                T_MIX:
                begin
                    oi_reg <= '0;
                    st_reg <= T_OUT;
                end
                T_OUT:
                    if (out_ready)
                    begin
                        if (oi_reg == (FIDX_W + 1)'(FACTORS - 1))
                            st_reg <= T_IDLE;
                        oi_reg <= oi_reg + 1'b1;
                    end
                default: st_reg <= T_IDLE;
            endcase
        end
    end

    assign out_valid = (st_reg == T_OUT);
    always_comb
    begin
        out_data.factor_index = 3'(oi_reg);
        out_data.weight_w = ws[oi_reg[FIDX_W-1:0]];
        out_data.weight_v = vs[oi_reg[FIDX_W-1:0]];
        out_data.last_of_run = (oi_reg == (FIDX_W + 1)'(FACTORS - 1));
    end
endmodule

[hw/rtl/lnge_checker.sv]
// Port-level checks for the epoch block.
module lnge_checker
    import lnge_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  logic out_valid,
    input  logic out_ready,
    input  out_item_t out_data
);
    // A waiting row stays offered until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input valid dropped while waiting");

    // A waiting result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // No row is taken while results are draining.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during drain");

    // The report walks factor indexes in order.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=>
        out_valid && out_data.factor_index == $past(out_data.factor_index) + 3'd1)
        else $error("factor order broken");
endmodule

bind logreg_nesterov_gradient_epoch_top lnge_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
